[rtl/bcs_pkg.sv]
package bcs_pkg;

  // Highest supported curve order and number of control points per item.
  localparam int unsigned MaxOrder  = 4;
  localparam int unsigned NumPoints = MaxOrder + 1;

  // Widths fixed by the register and result formats.
  localparam int unsigned OrderW  = 3;
  localparam int unsigned CountW  = 6;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 6;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] CfgCurveOrder  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgSampleCount = 1'b1;

  // Register values after reset.
  localparam logic [OrderW-1:0] OrderReset = 3'd3;
  localparam logic [CountW-1:0] CountReset = 6'd16;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD,
    ST_MUL,
    ST_ACC,
    ST_DROP,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              capture;   // store the control points of a new item
    logic              div_init;  // start 2^F / n and reset the step accumulator
    logic              div_step;  // one quotient bit
    logic              t_step;    // advance t to the next sample
    logic              load;      // copy control points into the working set
    logic              mul;       // register (w1 - w0) * t
    logic              acc;       // w0 + round(product), shift, insert result
    logic              drop;      // shift out the stale entry at a stage end
    logic [OrderW-1:0] ins_idx;   // slot that takes the new lerp result
  } dp_cmd_t;

endpackage

[rtl/bcs_in_if.sv]
interface bcs_in_if #(
  parameter int unsigned COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] p0_x;
  logic signed [COORD_WIDTH-1:0] p0_y;
  logic signed [COORD_WIDTH-1:0] p1_x;
  logic signed [COORD_WIDTH-1:0] p1_y;
  logic signed [COORD_WIDTH-1:0] p2_x;
  logic signed [COORD_WIDTH-1:0] p2_y;
  logic signed [COORD_WIDTH-1:0] p3_x;
  logic signed [COORD_WIDTH-1:0] p3_y;
  logic signed [COORD_WIDTH-1:0] p4_x;
  logic signed [COORD_WIDTH-1:0] p4_y;

  modport source (
    output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, p4_x, p4_y,
    input  ready
  );
  modport sink (
    input  valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, p4_x, p4_y,
    output ready
  );
endinterface

[rtl/bcs_out_if.sv]
interface bcs_out_if #(
  parameter int unsigned COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] curve_x;
  logic signed [COORD_WIDTH-1:0] curve_y;
  logic [5:0]                    sample_index;
  logic                          last_point;

  modport source (
    output valid, curve_x, curve_y, sample_index, last_point,
    input  ready
  );
  modport sink (
    input  valid, curve_x, curve_y, sample_index, last_point,
    output ready
  );
endinterface

[rtl/bezier_curve_sampler_core.sv]
// Channel   Dir  Payload
// in_ch     in   p0_x p0_y p1_x p1_y p2_x p2_y p3_x p3_y p4_x p4_y
// out_ch    out  curve_x curve_y sample_index last_point
// cfg       in   cfg_we_i cfg_idx_i cfg_data_i (curve_order, sample_count)
//
// Each item first runs a serial division of 2^F by n, then computes each point
// on the two shared multipliers (x and y lanes), n+1 points in all. A new item
// is taken only once the last point left.
// Reset restores curve_order = 3 and sample_count = 16.
// A stalled output simply holds the current point; no work is lost.
module bezier_curve_sampler_core #(
  parameter int unsigned COORD_WIDTH     = 16,
  parameter int unsigned T_FRACTION_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bcs_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bcs_pkg::CfgDataW-1:0]  cfg_data_i,
  bcs_in_if.sink                        in_ch,
  bcs_out_if.source                     out_ch
);
  import bcs_pkg::*;

  logic [OrderW-1:0] order_q;
  logic [CountW-1:0] count_q;
  logic [OrderW-1:0] order_eff;
  logic [CountW-1:0] count_eff;
  dp_cmd_t           cmd;

  logic signed [COORD_WIDTH-1:0] pts_x [NumPoints];
  logic signed [COORD_WIDTH-1:0] pts_y [NumPoints];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= OrderReset;
      count_q <= CountReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgCurveOrder:  order_q <= cfg_data_i[OrderW-1:0];
        CfgSampleCount: count_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Order clamps to linear..quartic, a zero sample count acts as one.
  always_comb begin
    if (order_q == '0) begin
      order_eff = OrderW'(1);
    end else if (order_q > OrderW'(MaxOrder)) begin
      order_eff = OrderW'(MaxOrder);
    end else begin
      order_eff = order_q;
    end
    count_eff = (count_q == '0) ? CountW'(1) : count_q;
  end

  // Control points gathered into arrays for the datapath.
  assign pts_x = '{in_ch.p0_x, in_ch.p1_x, in_ch.p2_x, in_ch.p3_x, in_ch.p4_x};
  assign pts_y = '{in_ch.p0_y, in_ch.p1_y, in_ch.p2_y, in_ch.p3_y, in_ch.p4_y};

  bcs_controller #(
    .T_FRACTION_BITS (T_FRACTION_BITS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .order_i        (order_eff),
    .count_i        (count_eff),
    .in_valid_i     (in_ch.valid),
    .in_ready_o     (in_ch.ready),
    .out_valid_o    (out_ch.valid),
    .out_ready_i    (out_ch.ready),
    .sample_index_o (out_ch.sample_index),
    .last_point_o   (out_ch.last_point),
    .cmd_o          (cmd)
  );

  bcs_datapath #(
    .COORD_WIDTH     (COORD_WIDTH),
    .T_FRACTION_BITS (T_FRACTION_BITS)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .count_i   (count_eff),
    .pts_x_i   (pts_x),
    .pts_y_i   (pts_y),
    .curve_x_o (out_ch.curve_x),
    .curve_y_o (out_ch.curve_y)
  );

  // The block never takes an item while it still offers a point.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ch.ready && out_ch.valid))
    else $error("input ready while a point is offered");

  // The last point carries the final step index.
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.last_point |-> out_ch.sample_index == count_eff)
    else $error("last point with wrong step index");

  // An accepted item closes the input until its points are done.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input reopened right after an item");

  // A point other than the last is followed by more work, not by idle.
  a_more_points: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.ready && !out_ch.last_point |=> !in_ch.ready)
    else $error("item ended before its last point");

endmodule

[rtl/bcs_datapath.sv]
module bcs_datapath #(
  parameter int unsigned COORD_WIDTH     = 16,
  parameter int unsigned T_FRACTION_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bcs_pkg::dp_cmd_t                    cmd_i,
  input  logic [bcs_pkg::CountW-1:0]          count_i,
  input  logic signed [COORD_WIDTH-1:0]       pts_x_i [bcs_pkg::NumPoints],
  input  logic signed [COORD_WIDTH-1:0]       pts_y_i [bcs_pkg::NumPoints],
  output logic signed [COORD_WIDTH-1:0]       curve_x_o,
  output logic signed [COORD_WIDTH-1:0]       curve_y_o
);
  import bcs_pkg::*;

  localparam int unsigned CW     = COORD_WIDTH;
  localparam int unsigned F      = T_FRACTION_BITS;
  localparam int unsigned TW     = F + 1;
  localparam int unsigned PROD_W = CW + F + 3;
  localparam int unsigned Lanes  = 2;

  // Captured control points, lane 0 is x and lane 1 is y.
  logic signed [CW-1:0] pin_q [Lanes][NumPoints];
  // Working set of de Casteljau's scheme.
  logic signed [CW-1:0] w_q   [Lanes][NumPoints];
  logic signed [CW-1:0] w_d   [Lanes][NumPoints];
  // Registered products, one multiplier per lane.
  logic signed [PROD_W-1:0] prod_q [Lanes];
  logic signed [PROD_W-1:0] prod_d [Lanes];
  logic signed [CW-1:0]     lerp   [Lanes];

  // Divider for 2^F / n, one quotient bit per cycle.
  logic [CountW-1:0] div_rem_q, div_rem_d;
  logic [TW-1:0]     div_quo_q, div_quo_d;
  logic              div_first_q;
  logic [CountW:0]   div_trial;
  logic              div_ge;

  // t kept as quotient and remainder of (k * 2^F + n/2) / n.
  logic [TW-1:0]     t_q, t_d;
  logic [CountW-1:0] tr_q, tr_d;
  logic [CountW:0]   tr_sum;
  logic              tr_wrap;

  // Restoring division step; the dividend 2^F has a one only in its top bit.
  always_comb begin
    div_trial = {div_rem_q, div_first_q};
    div_ge    = (div_trial >= {1'b0, count_i});
    div_rem_d = div_ge ? CountW'(div_trial - {1'b0, count_i}) : CountW'(div_trial);
    div_quo_d = {div_quo_q[TW-2:0], div_ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_first_q <= 1'b0;
    end else if (cmd_i.div_init) begin
      div_first_q <= 1'b1;
    end else if (cmd_i.div_step) begin
      div_first_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      div_rem_q <= '0;
      div_quo_q <= '0;
    end else if (cmd_i.div_step) begin
      div_rem_q <= div_rem_d;
      div_quo_q <= div_quo_d;
    end
  end

  // Exact step of t: add quotient and remainder of 2^F / n, carry on wrap.
  always_comb begin
    tr_sum  = {1'b0, tr_q} + {1'b0, div_rem_q};
    tr_wrap = (tr_sum >= {1'b0, count_i});
    tr_d    = tr_wrap ? CountW'(tr_sum - {1'b0, count_i}) : CountW'(tr_sum);
    t_d     = TW'(t_q + div_quo_q + TW'(tr_wrap));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      t_q  <= '0;
      tr_q <= count_i >> 1;
    end else if (cmd_i.t_step) begin
      t_q  <= t_d;
      tr_q <= tr_d;
    end
  end

  // Multiply the difference of the two front points by t, then round and add.
  always_comb begin
    logic signed [CW:0]     diff;
    logic signed [PROD_W-1:0] rsum;
    logic signed [PROD_W-1:0] shifted;
    for (int l = 0; l < Lanes; l++) begin
      diff      = {w_q[l][1][CW-1], w_q[l][1]} - {w_q[l][0][CW-1], w_q[l][0]};
      prod_d[l] = diff * $signed({1'b0, t_q});
      rsum      = prod_q[l] + $signed(PROD_W'(1) << (F - 1));
      shifted   = rsum >>> F;
      lerp[l]   = w_q[l][0] + shifted[CW-1:0];
    end
  end

  // Working set update: load, shift with insert, or plain shift.
  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      w_d[l] = w_q[l];
      if (cmd_i.load) begin
        w_d[l] = pin_q[l];
      end else if (cmd_i.acc || cmd_i.drop) begin
        for (int j = 0; j < NumPoints - 1; j++) begin
          w_d[l][j] = w_q[l][j+1];
        end
        if (cmd_i.acc) begin
          w_d[l][cmd_i.ins_idx] = lerp[l];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pin_q[0] <= pts_x_i;
      pin_q[1] <= pts_y_i;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_d;
    end
    w_q <= w_d;
  end

  // The front entry holds the finished point while it is offered.
  assign curve_x_o = w_q[0][0];
  assign curve_y_o = w_q[1][0];

endmodule

[rtl/bcs_controller.sv]
module bcs_controller #(
  parameter int unsigned T_FRACTION_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [bcs_pkg::OrderW-1:0]  order_i,
  input  logic [bcs_pkg::CountW-1:0]  count_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [bcs_pkg::CountW-1:0]  sample_index_o,
  output logic                        last_point_o,
  output bcs_pkg::dp_cmd_t            cmd_o
);
  import bcs_pkg::*;

  localparam int unsigned DivSteps = T_FRACTION_BITS + 1;
  localparam int unsigned DcntW    = $clog2(DivSteps + 1);

  state_e            state_q, state_d;
  logic [CountW-1:0] k_q, k_d;
  logic [OrderW-1:0] s_q, s_d;
  logic [OrderW-1:0] i_q, i_d;
  logic [DcntW-1:0]  dcnt_q, dcnt_d;

  logic in_fire, out_fire, div_done, stage_end, last_k;

  assign in_fire   = in_valid_i && (state_q == ST_IDLE);
  assign out_fire  = out_ready_i && (state_q == ST_EMIT);
  assign div_done  = (dcnt_q == DcntW'(DivSteps - 1));
  assign stage_end = (i_q == OrderW'(s_q - OrderW'(1)));
  assign last_k    = (k_q == count_i);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_LOAD;
      ST_LOAD: state_d = ST_MUL;
      ST_MUL:  state_d = ST_ACC;
      ST_ACC:  state_d = stage_end ? ST_DROP : ST_MUL;
      ST_DROP: state_d = (s_q == OrderW'(1)) ? ST_EMIT : ST_MUL;
      ST_EMIT: begin
        if (out_ready_i) state_d = last_k ? ST_IDLE : ST_LOAD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Counters for divider steps, sample, stage and lerp position.
  always_comb begin
    k_d    = k_q;
    s_d    = s_q;
    i_d    = i_q;
    dcnt_d = dcnt_q;
    if (in_fire) begin
      k_d    = '0;
      dcnt_d = '0;
    end
    if (state_q == ST_DIV) begin
      dcnt_d = DcntW'(dcnt_q + DcntW'(1));
    end
    if (state_q == ST_LOAD) begin
      s_d = order_i;
      i_d = '0;
    end
    if (state_q == ST_ACC) begin
      i_d = OrderW'(i_q + OrderW'(1));
    end
    if (state_q == ST_DROP) begin
      s_d = OrderW'(s_q - OrderW'(1));
      i_d = '0;
    end
    if (out_fire && !last_k) begin
      k_d = CountW'(k_q + CountW'(1));
    end
  end

  // Datapath commands and handshake outputs.
  always_comb begin
    cmd_o          = '0;
    cmd_o.ins_idx  = s_q;
    cmd_o.capture  = in_fire;
    cmd_o.div_init = in_fire;
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.load     = (state_q == ST_LOAD);
    cmd_o.mul      = (state_q == ST_MUL);
    cmd_o.acc      = (state_q == ST_ACC);
    cmd_o.drop     = (state_q == ST_DROP);
    cmd_o.t_step   = out_fire && !last_k;
    in_ready_o     = (state_q == ST_IDLE);
    out_valid_o    = (state_q == ST_EMIT);
    sample_index_o = k_q;
    last_point_o   = last_k;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      s_q     <= '0;
      i_q     <= '0;
      dcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      s_q     <= s_d;
      i_q     <= i_d;
      dcnt_q  <= dcnt_d;
    end
  end

endmodule

[sim/bcs_curve_checker.sv]
module bcs_curve_checker #(
  parameter int unsigned COORD_WIDTH     = 16,
  parameter int unsigned T_FRACTION_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bcs_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [bcs_pkg::CfgDataW-1:0] cfg_data_i,
  bcs_in_if                            in_mon,
  bcs_out_if                           out_mon,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           checked_o
);
  import bcs_pkg::*;

  localparam int    MaxReports = 10;
  localparam longint RoundHalf = longint'(1) << (T_FRACTION_BITS - 1);

  typedef logic [NumPoints-1:0][COORD_WIDTH-1:0] lane_pts_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] x;
    logic [COORD_WIDTH-1:0] y;
    logic [CountW-1:0]      idx;
    logic                   last;
  } curve_point_t;

  // Mirror of the block's registers, tracked from the write port.
  logic [OrderW-1:0] order_q;
  logic [CountW-1:0] count_q;

  curve_point_t point_q[$];
  int           err_cnt;
  int           checked_cnt;

  // De Casteljau evaluation of one coordinate lane at parameter t (Q0.F, 1.0 allowed).
  // Each stage moves a toward b by (b - a) * t, rounded to nearest, ties upward.
  function automatic longint casteljau_eval(input lane_pts_t pts, input int ord,
                                            input longint t);
    longint w [NumPoints];
    for (int i = 0; i < NumPoints; i++) w[i] = longint'($signed(pts[i]));
    for (int s = ord; s > 0; s--) begin
      for (int i = 0; i < s; i++) begin
        w[i] = w[i] + ((((w[i+1] - w[i]) * t) + RoundHalf) >>> T_FRACTION_BITS);
      end
    end
    return w[0];
  endfunction

  // Expand one accepted item into its sampled curve points.
  task automatic queue_curve_points();
    lane_pts_t    xs;
    lane_pts_t    ys;
    int           ord;
    int           n;
    longint       t;
    curve_point_t pt;
    xs = {in_mon.p4_x, in_mon.p3_x, in_mon.p2_x, in_mon.p1_x, in_mon.p0_x};
    ys = {in_mon.p4_y, in_mon.p3_y, in_mon.p2_y, in_mon.p1_y, in_mon.p0_y};
    // Order zero runs as linear, anything above quartic saturates.
    ord = int'(order_q);
    if (ord < 1) ord = 1;
    if (ord > MaxOrder) ord = MaxOrder;
    // A zero step count behaves as a single step.
    n = int'(count_q);
    if (n == 0) n = 1;
    for (int k = 0; k <= n; k++) begin
      t       = ((longint'(k) << T_FRACTION_BITS) + longint'(n / 2)) / longint'(n);
      pt.x    = COORD_WIDTH'(casteljau_eval(xs, ord, t));
      pt.y    = COORD_WIDTH'(casteljau_eval(ys, ord, t));
      pt.idx  = CountW'(k);
      pt.last = (k == n);
      point_q.insert(point_q.size(), pt);
    end
  endtask

  // Compare one emitted point with the oldest predicted one.
  task automatic check_point();
    curve_point_t want;
    curve_point_t got;
    got.x    = out_mon.curve_x;
    got.y    = out_mon.curve_y;
    got.idx  = out_mon.sample_index;
    got.last = out_mon.last_point;
    if (point_q.size() == 0) begin
      if (err_cnt < MaxReports) begin
        $display("unexpected point: x=%0d y=%0d k=%0d last=%0b",
                 $signed(got.x), $signed(got.y), got.idx, got.last);
      end
      err_cnt++;
    end else begin
      want = point_q.pop_front();
      checked_cnt++;
      if (want != got) begin
        if (err_cnt < MaxReports) begin
          $display({"point mismatch: expected x=%0d y=%0d k=%0d last=%0b, ",
                    "got x=%0d y=%0d k=%0d last=%0b"},
                   $signed(want.x), $signed(want.y), want.idx, want.last,
                   $signed(got.x), $signed(got.y), got.idx, got.last);
        end
        err_cnt++;
      end
    end
  endtask

  // Watch the register port and both channels at every rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= OrderReset;
      count_q <= CountReset;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgCurveOrder:  order_q <= cfg_data_i[OrderW-1:0];
          CfgSampleCount: count_q <= cfg_data_i[CountW-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) check_point();
      if (in_mon.valid && in_mon.ready) queue_curve_points();
      fail_count_o <= err_cnt;
      pending_o    <= point_q.size();
      checked_o    <= checked_cnt;
    end
  end

endmodule

[sim/tb_bezier_curve_sampler_core.sv]
module tb_bezier_curve_sampler_core;
  import bcs_pkg::*;

  localparam int unsigned CoordW      = 16;
  localparam int unsigned TFracBits   = 16;
  localparam int          DrainCycles = 32;
  localparam int          LimitCycles = 3_000_000;
  localparam int          RandItems   = 230;
  localparam int          NumPhases   = 4;
  localparam int          SegPerPhase = 4;

  localparam logic [CoordW-1:0] CoordMax = 16'h7FFF;
  localparam logic [CoordW-1:0] CoordMin = 16'h8000;

  typedef struct packed {
    logic [NumPoints-1:0][CoordW-1:0] x;
    logic [NumPoints-1:0][CoordW-1:0] y;
  } ctrl_pts_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  int send_idle_pct;
  int recv_stall_pct;
  int items_sent;
  int settings_used;
  int cycle_cnt = 0;
  int mismatches;
  int pending;
  int checked;

  bcs_in_if  #(.COORD_WIDTH(CoordW)) in_ch ();
  bcs_out_if #(.COORD_WIDTH(CoordW)) out_ch ();

  bezier_curve_sampler_core #(
    .COORD_WIDTH    (CoordW),
    .T_FRACTION_BITS(TFracBits)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  bcs_curve_checker #(
    .COORD_WIDTH    (CoordW),
    .T_FRACTION_BITS(TFracBits)
  ) u_curve_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count_o(mismatches),
    .pending_o   (pending),
    .checked_o   (checked)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LimitCycles) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Output side: ready drops at random according to the current stall rate.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Write one register; the enable is held for exactly one edge.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stop sending and wait until every predicted point has come out.
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Registers change only while the block is idle.
  task automatic set_curve(input int ord, input int cnt);
    drain_block();
    write_reg(CfgCurveOrder, CfgDataW'(ord));
    write_reg(CfgSampleCount, CfgDataW'(cnt));
    settings_used++;
  endtask

  // Offer one item, with optional idle cycles ahead of it, and wait for acceptance.
  task automatic send_curve(input ctrl_pts_t pts);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.p0_x  <= pts.x[0];
    in_ch.p0_y  <= pts.y[0];
    in_ch.p1_x  <= pts.x[1];
    in_ch.p1_y  <= pts.y[1];
    in_ch.p2_x  <= pts.x[2];
    in_ch.p2_y  <= pts.y[2];
    in_ch.p3_x  <= pts.x[3];
    in_ch.p3_y  <= pts.y[3];
    in_ch.p4_x  <= pts.x[4];
    in_ch.p4_y  <= pts.y[4];
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  // Fixed corner patterns: all maximum, all minimum, min/max alternating, and a mixed one.
  function automatic ctrl_pts_t pattern_pts(input int kind);
    ctrl_pts_t p;
    for (int i = 0; i < NumPoints; i++) begin
      case (kind)
        0: begin
          p.x[i] = CoordMax;
          p.y[i] = CoordMax;
        end
        1: begin
          p.x[i] = CoordMin;
          p.y[i] = CoordMin;
        end
        2: begin
          p.x[i] = (i % 2 == 0) ? CoordMin : CoordMax;
          p.y[i] = (i % 2 == 0) ? CoordMax : CoordMin;
        end
        default: begin
          p.x[i] = (i % 2 == 0) ? '0 : '1;
          p.y[i] = (i < 2) ? CoordMax : CoordMin;
        end
      endcase
    end
    return p;
  endfunction

  // Mostly uniform coordinates, with corner values mixed in now and then.
  function automatic logic [CoordW-1:0] random_coord();
    if ($urandom_range(7) == 0) begin
      case ($urandom_range(3))
        0:       return CoordMax;
        1:       return CoordMin;
        2:       return '0;
        default: return '1;
      endcase
    end
    return CoordW'($urandom());
  endfunction

  function automatic ctrl_pts_t random_pts();
    ctrl_pts_t p;
    for (int i = 0; i < NumPoints; i++) begin
      p.x[i] = random_coord();
      p.y[i] = random_coord();
    end
    return p;
  endfunction

  // Reset, directed corners, then random items across the flow-control phases.
  initial begin
    int ord;
    int cnt;
    rst_ni         <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_idx        <= '0;
    cfg_data       <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.p0_x     <= '0;
    in_ch.p0_y     <= '0;
    in_ch.p1_x     <= '0;
    in_ch.p1_y     <= '0;
    in_ch.p2_x     <= '0;
    in_ch.p2_y     <= '0;
    in_ch.p3_x     <= '0;
    in_ch.p3_y     <= '0;
    in_ch.p4_x     <= '0;
    in_ch.p4_y     <= '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    items_sent     = 0;
    settings_used  = 1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Register values after reset: cubic with sixteen steps.
    for (int k = 0; k < 4; k++) send_curve(pattern_pts(k));
    // Linear with a single step.
    set_curve(1, 1);
    send_curve(pattern_pts(2));
    send_curve(pattern_pts(3));
    // Order zero and a zero step count both fall back to one.
    set_curve(0, 0);
    send_curve(pattern_pts(2));
    // Widest step count on quadratic and quartic curves.
    set_curve(2, 63);
    send_curve(pattern_pts(2));
    set_curve(4, 63);
    send_curve(pattern_pts(3));
    // Orders above quartic saturate, then quartic and cubic items follow.
    set_curve(7, 5);
    send_curve(pattern_pts(2));
    set_curve(5, 2);
    send_curve(pattern_pts(3));
    set_curve(4, 3);
    for (int k = 0; k < 4; k++) send_curve(pattern_pts(k));
    set_curve(3, 1);
    send_curve(pattern_pts(3));

    // Random items, a few register settings per flow-control phase.
    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_block();
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 61;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 61;
        end
        default: begin
          send_idle_pct  = 24;
          recv_stall_pct = 24;
        end
      endcase
      for (int seg = 0; seg < SegPerPhase; seg++) begin
        ord = ($urandom_range(3) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
        if (ph == 1 && seg == 2) begin
          cnt = 63;
        end else if ($urandom_range(7) == 0) begin
          cnt = $urandom_range(13, 63);
        end else begin
          cnt = $urandom_range(0, 12);
        end
        set_curve(ord, cnt);
        for (int i = 0; i < RandItems / (NumPhases * SegPerPhase); i++) begin
          send_curve(random_pts());
        end
      end
    end

    drain_block();
    $display("Checked %0d curve points from %0d items over %0d register settings.",
             checked, items_sent, settings_used);
    $display("Flow control ran free, with sender gaps, with output stalls, and with both.");
    if (pending != 0) $display("%0d predicted points never came out", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
